>>> hw/rtl/ftcg_pkg.sv
// Shared types, constants and codes of the floor texture coordinate generator.
package ftcg_pkg;

  localparam int SCREEN_WIDTH  = 1024;  // power of two: the step divide is a shift
  localparam int SCREEN_HEIGHT = 768;
  localparam int HALF_H        = SCREEN_HEIGHT / 2;
  localparam int FRAC_BITS     = 30;
  localparam int WORLD_W       = 48;
  localparam int ROW_W         = 10;
  localparam int CMP_W         = 13;
  localparam int D_W           = $clog2(HALF_H);
  localparam int RD_W          = FRAC_BITS + $clog2(HALF_H + 1);
  localparam int CC_W          = $clog2(SCREEN_WIDTH) + 1;
  localparam int W_LOG2        = $clog2(SCREEN_WIDTH);
  localparam int OP_W          = 18;
  localparam int PROD_W        = RD_W + 1 + OP_W;
  localparam int TEX_W         = 10;
  localparam int LG_W          = 4;
  localparam int ADDR_W        = 5;

  localparam logic [2:0] REG_POS_X   = 3'd0;
  localparam logic [2:0] REG_POS_Y   = 3'd1;
  localparam logic [2:0] REG_DIR_X   = 3'd2;
  localparam logic [2:0] REG_DIR_Y   = 3'd3;
  localparam logic [2:0] REG_PLANE_X = 3'd4;
  localparam logic [2:0] REG_PLANE_Y = 3'd5;
  localparam logic [2:0] REG_TEX_WL  = 3'd6;
  localparam logic [2:0] REG_TEX_HL  = 3'd7;

  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row_index;
  } in_item_t;

  typedef struct packed {
    logic [TEX_W-1:0] column;
    logic [TEX_W-1:0] tex_x;
    logic [TEX_W-1:0] tex_y;
    logic             last_in_row;
  } out_item_t;

  typedef struct packed {
    logic            is_pixel;
    logic [D_W-1:0]  divisor;
  } cmd_t;

  typedef struct packed {
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] plane_x;
    logic signed [15:0] plane_y;
    logic [LG_W-1:0]    tex_wl;
    logic [LG_W-1:0]    tex_hl;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_MUL,
    ST_ACC
  } state_t;

endpackage

>>> hw/rtl/ftcg_front.sv
// Front end: accepts items, clamps row starts to a divisor, queues commands.
module ftcg_front import ftcg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  in_item_t in_data,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  cmd_t            mem_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic [CMP_W-1:0] r_c;
  cmd_t            cmd_c;
  logic            wr_c, rd_c;

  always_comb begin
    r_c = {{(CMP_W-ROW_W){1'b0}}, in_data.row_index};
    if (r_c > CMP_W'(SCREEN_HEIGHT - 1)) r_c = CMP_W'(SCREEN_HEIGHT - 1);
    if (r_c <= CMP_W'(HALF_H)) r_c = CMP_W'(HALF_H + 1);
    cmd_c.is_pixel = (in_data.kind == KIND_PIXEL);
    cmd_c.divisor  = D_W'(r_c - CMP_W'(HALF_H));
  end

  assign full    = (cnt_r == 2'd2);
  assign q_valid = (cnt_r != 2'd0);
  assign q_cmd   = mem_r[rp_r];
  assign wr_c    = push && !full;
  assign rd_c    = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr_c) mem_r[wp_r] <= cmd_c;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_c) wp_r <= ~wp_r;
      if (rd_c) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_c} - {1'b0, rd_c};
    end
  end

endmodule

>>> hw/rtl/ftcg_div.sv
// Restoring divider: row distance = (HALF_H << FRAC_BITS) / divisor, one bit a cycle.
module ftcg_div import ftcg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [D_W-1:0]  divisor,
  output logic            done,
  output logic [RD_W-1:0] quotient
);

  localparam logic [RD_W-1:0] DIVIDEND = RD_W'(HALF_H) << FRAC_BITS;
  localparam int CNT_W = $clog2(RD_W + 1);

  logic [RD_W-1:0]  num_r, q_r;
  logic [D_W:0]     rem_r;
  logic [D_W-1:0]   d_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [D_W:0]     rem_s;
  logic             ge_c;

  always_comb begin
    rem_s = {rem_r[D_W-1:0], num_r[RD_W-1]};
    ge_c  = (rem_s >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= DIVIDEND;
      rem_r <= '0;
      d_r   <= divisor;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[RD_W-2:0], 1'b0};
      rem_r <= ge_c ? rem_s - {1'b0, d_r} : rem_s;
      q_r   <= {q_r[RD_W-2:0], ge_c};
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(RD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

>>> hw/rtl/ftcg_back.sv
// Back end: row setup sequencer, pixel stepping and the result queue.
module ftcg_back import ftcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cmd_t      q_cmd,
  output logic      q_pop,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data
);

  state_t state_r, state_nxt;
  logic   div_start, div_done, emit;
  logic [RD_W-1:0] rd_q;

  cfg_t                      cfg_r;
  logic [RD_W-1:0]           rd_r;
  logic [1:0]                idx_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [WORLD_W-1:0]        wx_r, wy_r, sx_r, sy_r;
  logic [CC_W-1:0]           cc_r;

  out_item_t  om_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;

  logic signed [OP_W-1:0]    op_c;
  logic signed [PROD_W-1:0]  t14_c, t24_c, tq_c;
  logic [WORLD_W-1:0]        val_c;
  logic                      last_c;
  out_item_t                 res_c;

  ftcg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(q_cmd.divisor),
    .done(div_done), .quotient(rd_q)
  );

  function automatic logic [TEX_W-1:0] tex_coord(input logic [WORLD_W-1:0] w,
                                                 input logic [LG_W-1:0] lg);
    logic [LG_W-1:0]    n;
    logic [WORLD_W-1:0] s;
    n = (lg > LG_W'(TEX_W)) ? LG_W'(TEX_W) : lg;
    s = w >> (FRAC_BITS - int'(n));
    return s[TEX_W-1:0] & ((TEX_W'(1) << n) - TEX_W'(1));
  endfunction

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    q_pop     = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        if (q_valid) begin
          if (q_cmd.is_pixel) begin
            if (ocnt_r != 2'd2) begin
              emit  = 1'b1;
              q_pop = 1'b1;
            end
          end else begin
            div_start = 1'b1;
            q_pop     = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: if (div_done) state_nxt = ST_MUL;
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (idx_r == 2'd3) ? ST_RUN : ST_MUL;
      default: state_nxt = ST_RUN;
    endcase
  end

  // Operand per setup step: the two start offsets, then the two steps (-2 * plane).
  always_comb begin
    case (idx_r)
      2'd0:    op_c = OP_W'(cfg_r.dir_x) + OP_W'(cfg_r.plane_x);
      2'd1:    op_c = OP_W'(cfg_r.dir_y) + OP_W'(cfg_r.plane_y);
      2'd2:    op_c = -(OP_W'(cfg_r.plane_x) <<< 1);
      default: op_c = -(OP_W'(cfg_r.plane_y) <<< 1);
    endcase
  end

  // Truncation toward zero: bias negative products before the arithmetic shift.
  always_comb begin
    t14_c = (prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << 14) - 1) : PROD_W'(0))) >>> 14;
    t24_c = (prod_r + (prod_r[PROD_W-1] ? PROD_W'((1 << (14 + W_LOG2)) - 1) : PROD_W'(0)))
            >>> (14 + W_LOG2);
    tq_c  = idx_r[1] ? t24_c : t14_c;
    val_c = tq_c[WORLD_W-1:0];
  end

  always_comb begin
    last_c            = (cc_r >= CC_W'(SCREEN_WIDTH - 1));
    res_c.column      = cc_r[TEX_W-1:0];
    res_c.tex_x       = tex_coord(wx_r, cfg.tex_wl);
    res_c.tex_y       = tex_coord(wy_r, cfg.tex_hl);
    res_c.last_in_row = last_c;
  end

  always_ff @(posedge clk) begin
    if (div_start) cfg_r <= cfg;
    if (div_done && state_r == ST_DIV) rd_r <= rd_q;
    if (state_r == ST_MUL) prod_r <= $signed({1'b0, rd_r}) * op_c;
    if (emit) om_r[owp_r] <= res_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      idx_r   <= 2'd0;
      wx_r    <= '0;
      wy_r    <= '0;
      sx_r    <= '0;
      sy_r    <= '0;
      cc_r    <= '0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (div_start) idx_r <= 2'd0;
      if (state_r == ST_ACC) begin
        idx_r <= idx_r + 2'd1;
        case (idx_r)
          2'd0:    wx_r <= WORLD_W'({cfg_r.pos_x, 14'd0}) + val_c;
          2'd1:    wy_r <= WORLD_W'({cfg_r.pos_y, 14'd0}) + val_c;
          2'd2:    sx_r <= val_c;
          default: begin
            sy_r <= val_c;
            cc_r <= '0;
          end
        endcase
      end
      if (emit) begin
        wx_r <= wx_r + sx_r;
        wy_r <= wy_r + sy_r;
        cc_r <= last_c ? '0 : cc_r + 1'b1;
        owp_r <= ~owp_r;
      end
      if (pop && !empty) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, emit} - {1'b0, pop && !empty};
    end
  end

  assign empty    = (ocnt_r == 2'd0);
  assign out_data = om_r[orp_r];

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("result queue count overflow");
  a_emit_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (state_r == ST_RUN && ocnt_r != 2'd2))
    else $error("pixel emitted outside run state or into a full queue");
  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_done) |=> (state_r == ST_MUL && idx_r == 2'd0))
    else $error("setup did not begin after the divide");
  a_setup_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && idx_r == 2'd3) |=> (state_r == ST_RUN && cc_r == '0))
    else $error("row setup did not finish cleanly");

endmodule

>>> hw/rtl/floor_texture_coordinate_generator_core.sv
// Top level: configuration registers, front end and back end of the floor caster.
//
// Input channel: push/full with in_data (kind, row_index). A beat is taken when
// push is high and full is low; a two-entry command queue sits behind it.
// Result channel: empty/pop with out_data (column, tex_x, tex_y, last_in_row).
// The oldest result is shown while empty is low and leaves when pop is high.
// Configuration: APB-style port, register i at byte address 4*i, pready tied high.
// Position, direction and plane are sampled when a row start begins its setup;
// the texture sizes are read as each pixel is produced.
// Pixel beats produce one result each, at one per cycle while the back end is in
// its run state and the result queue has room; a result is registered in the
// result queue before it reaches the result ports. A row start produces no result
// and occupies the back end to dispatch, for the bit-serial divide of the 39-bit
// row distance and for four shared multiply-and-truncate steps.
// When pop stays low the two-entry result queue fills, pixel beats back up
// into the command queue and full rises; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues, restores the register
// defaults and zeroes the world position, steps and column counter.
module floor_texture_coordinate_generator_core import ftcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_item_t          in_data,
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t       cfg_r;
  logic       wr_c;
  logic [2:0] idx_c;
  logic       q_valid, q_pop;
  cmd_t       q_cmd;

  assign pready = 1'b1;
  assign idx_c  = paddr[4:2];
  assign wr_c   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_x   <= 32'd0;
      cfg_r.pos_y   <= 32'd0;
      cfg_r.dir_x   <= 16'sd16384;
      cfg_r.dir_y   <= 16'sd0;
      cfg_r.plane_x <= 16'sd0;
      cfg_r.plane_y <= 16'sd10813;
      cfg_r.tex_wl  <= 4'd6;
      cfg_r.tex_hl  <= 4'd6;
    end else if (wr_c) begin
      unique case (idx_c)
        REG_POS_X:   cfg_r.pos_x   <= pwdata;
        REG_POS_Y:   cfg_r.pos_y   <= pwdata;
        REG_DIR_X:   cfg_r.dir_x   <= pwdata[15:0];
        REG_DIR_Y:   cfg_r.dir_y   <= pwdata[15:0];
        REG_PLANE_X: cfg_r.plane_x <= pwdata[15:0];
        REG_PLANE_Y: cfg_r.plane_y <= pwdata[15:0];
        REG_TEX_WL:  cfg_r.tex_wl  <= pwdata[LG_W-1:0];
        REG_TEX_HL:  cfg_r.tex_hl  <= pwdata[LG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx_c)
      REG_POS_X:   prdata = cfg_r.pos_x;
      REG_POS_Y:   prdata = cfg_r.pos_y;
      REG_DIR_X:   prdata = {16'd0, cfg_r.dir_x};
      REG_DIR_Y:   prdata = {16'd0, cfg_r.dir_y};
      REG_PLANE_X: prdata = {16'd0, cfg_r.plane_x};
      REG_PLANE_Y: prdata = {16'd0, cfg_r.plane_y};
      REG_TEX_WL:  prdata = {28'd0, cfg_r.tex_wl};
      REG_TEX_HL:  prdata = {28'd0, cfg_r.tex_hl};
      default:     prdata = 32'd0;
    endcase
  end

  ftcg_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  ftcg_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .empty(empty), .pop(pop), .out_data(out_data)
  );

endmodule
